>>> rtl/tlb_pkg.sv
package tlb_pkg;

   localparam int ENTRIES_DEFAULT     = 4;
   localparam int KEY_WIDTH_DEFAULT   = 19;
   localparam int FRAME_WIDTH_DEFAULT = 19;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_FILL   = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic search;
      logic update;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_fill;
   } dp_status_type;

endpackage

>>> rtl/tlb_lru_lookup_fill_core.sv
// Fully associative translation buffer with least-recently-used replacement.
// Request channel: drive req_command, req_key and req_frame_in with start high;
// the item is taken at a clock edge where start is high and busy is low.
// A lookup (command 0) returns one item on rsp_hit and rsp_frame_out, marked by
// rsp_strobe for a single cycle. A miss returns hit low and a zero frame and
// leaves the buffer unchanged.
// A fill (command 1) returns nothing; it writes the entry already holding the
// key, or else the least recently used entry.
// Each item runs through the steps capture, then the parallel key compare and
// victim search, then rank update and frame RAM access; a lookup adds a last
// step that presents the result of the frame RAM's registered read. A new
// item is taken only once the previous one is finished.
// The receiver cannot stall: a result is valid only in its strobe cycle.
// Synchronous reset invalidates all entries and sets each rank to its index;
// no clearing pass is needed, and start is honored in the cycle after reset.
module tlb_lru_lookup_fill_core #(
   parameter int ENTRIES     = tlb_pkg::ENTRIES_DEFAULT,
   parameter int KEY_WIDTH   = tlb_pkg::KEY_WIDTH_DEFAULT,
   parameter int FRAME_WIDTH = tlb_pkg::FRAME_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_command,
   input  logic [KEY_WIDTH-1:0]   req_key,
   input  logic [FRAME_WIDTH-1:0] req_frame_in,
   output logic                   rsp_strobe,
   output logic                   rsp_hit,
   output logic [FRAME_WIDTH-1:0] rsp_frame_out
);

   tlb_pkg::ctrl_cmd_type  cmd;
   tlb_pkg::dp_status_type status;

   tlb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   tlb_dp #(
      .ENTRIES     (ENTRIES),
      .KEY_WIDTH   (KEY_WIDTH),
      .FRAME_WIDTH (FRAME_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_command   (req_command),
      .req_key       (req_key),
      .req_frame_in  (req_frame_in),
      .rsp_hit       (rsp_hit),
      .rsp_frame_out (rsp_frame_out)
   );

endmodule

>>> rtl/tlb_ram.sv
module tlb_ram #(
   parameter int WIDTH = tlb_pkg::FRAME_WIDTH_DEFAULT,
   parameter int DEPTH = tlb_pkg::ENTRIES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/tlb_ctrl.sv
module tlb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  tlb_pkg::dp_status_type status,
   output tlb_pkg::ctrl_cmd_type  cmd,
   output logic                   busy,
   output logic                   rsp_strobe
);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_SEARCH  = 4'b0010,
      ST_UPDATE  = 4'b0100,
      ST_RESPOND = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.search = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.is_fill ? ST_IDLE : ST_RESPOND;
         end
         ST_RESPOND: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_RESPOND);

endmodule

>>> rtl/tlb_dp.sv
module tlb_dp #(
   parameter int ENTRIES     = tlb_pkg::ENTRIES_DEFAULT,
   parameter int KEY_WIDTH   = tlb_pkg::KEY_WIDTH_DEFAULT,
   parameter int FRAME_WIDTH = tlb_pkg::FRAME_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tlb_pkg::ctrl_cmd_type  cmd,
   output tlb_pkg::dp_status_type status,
   input  logic                   req_command,
   input  logic [KEY_WIDTH-1:0]   req_key,
   input  logic [FRAME_WIDTH-1:0] req_frame_in,
   output logic                   rsp_hit,
   output logic [FRAME_WIDTH-1:0] rsp_frame_out
);

   localparam int IDX_W = $clog2(ENTRIES);

   logic                   cmd_ff;
   logic [KEY_WIDTH-1:0]   key_ff;
   logic [FRAME_WIDTH-1:0] frame_ff;

   logic                 valid_ff [ENTRIES];
   logic [KEY_WIDTH-1:0] entry_key_ff [ENTRIES];
   logic [IDX_W-1:0]     rank_ff [ENTRIES];

   logic             hit_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] old_rank_ff;

   logic [ENTRIES-1:0] match;
   logic [ENTRIES-1:0] lowest;
   logic [ENTRIES-1:0] sel;
   logic               any_match;
   logic [IDX_W-1:0]   sel_idx;
   logic [IDX_W-1:0]   sel_rank;

   logic             do_promote;
   logic             ram_wr;
   logic             ram_rd;
   logic [FRAME_WIDTH-1:0] ram_rdata;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff   <= req_command;
         key_ff   <= req_key;
         frame_ff <= req_frame_in;
      end
   end

   // Keys are unique among valid entries, so at most one bit of match is set,
   // and exactly one entry holds rank zero.
   always_comb begin
      sel_idx  = '0;
      sel_rank = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i]  = valid_ff[i] && (entry_key_ff[i] == key_ff);
         lowest[i] = (rank_ff[i] == '0);
      end
      any_match = |match;
      sel       = any_match ? match : lowest;
      for (int i = 0; i < ENTRIES; i++) begin
         sel_idx  = sel_idx  | (sel[i] ? IDX_W'(i) : '0);
         sel_rank = sel_rank | (sel[i] ? rank_ff[i] : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.search) begin
         hit_ff      <= any_match;
         idx_ff      <= sel_idx;
         old_rank_ff <= sel_rank;
      end
   end

   assign do_promote = cmd.update && ((cmd_ff == tlb_pkg::CMD_FILL) || hit_ff);
   assign ram_wr     = cmd.update && (cmd_ff == tlb_pkg::CMD_FILL);
   assign ram_rd     = cmd.update && (cmd_ff == tlb_pkg::CMD_LOOKUP) && hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
            rank_ff[i]  <= IDX_W'(i);
         end
      end else begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (do_promote) begin
               if (idx_ff == IDX_W'(i)) begin
                  rank_ff[i] <= IDX_W'(ENTRIES - 1);
               end else if (rank_ff[i] > old_rank_ff) begin
                  rank_ff[i] <= rank_ff[i] - 1'b1;
               end
            end
            if (ram_wr && (idx_ff == IDX_W'(i))) begin
               valid_ff[i] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ram_wr) begin
         entry_key_ff[idx_ff] <= key_ff;
      end
   end

   tlb_ram #(
      .WIDTH (FRAME_WIDTH),
      .DEPTH (ENTRIES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .rd_en   (ram_rd),
      .addr    (idx_ff),
      .wr_data (frame_ff),
      .rd_data (ram_rdata)
   );

   assign status.is_fill = (cmd_ff == tlb_pkg::CMD_FILL);
   assign rsp_hit        = hit_ff;
   assign rsp_frame_out  = hit_ff ? ram_rdata : '0;

endmodule

>>> rtl/tlb_checker.sv
module tlb_checker #(
   parameter int FRAME_WIDTH = tlb_pkg::FRAME_WIDTH_DEFAULT
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   req_command,
   input logic                   rsp_strobe,
   input logic                   rsp_hit,
   input logic [FRAME_WIDTH-1:0] rsp_frame_out
);

   logic accept;
   assign accept = start && !busy;

   // A lookup always answers with a result strobe after it is taken.
   assert property (@(posedge clock) disable iff (reset)
      accept && (req_command == tlb_pkg::CMD_LOOKUP) |-> ##3 rsp_strobe)
      else $error("lookup did not answer on time");

   // A fill finishes without a result and frees the block.
   assert property (@(posedge clock) disable iff (reset)
      accept && (req_command == tlb_pkg::CMD_FILL) |-> ##3 (!busy && !rsp_strobe))
      else $error("fill did not complete as expected");

   // A result only appears while an item is in flight.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy && !accept)
      else $error("result strobe outside an item");

   // A miss reports a zero frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_hit |-> (rsp_frame_out == '0))
      else $error("miss returned a nonzero frame");

endmodule

bind tlb_lru_lookup_fill_core tlb_checker #(
   .FRAME_WIDTH (FRAME_WIDTH)
) u_tlb_checker (.*);

>>> dv/tlb_lru_lookup_fill_core_tb.sv
`timescale 1ns / 100ps

module tlb_lru_lookup_fill_core_tb;

   localparam int ENTRIES       = tlb_pkg::ENTRIES_DEFAULT;
   localparam int KEY_W         = tlb_pkg::KEY_WIDTH_DEFAULT;
   localparam int FRAME_W       = tlb_pkg::FRAME_WIDTH_DEFAULT;
   localparam int RANK_W        = $clog2(ENTRIES);
   localparam int POOL_SIZE     = 6;
   localparam int DRAIN_LIMIT   = 200;
   localparam int SETTLE_CYCLES = 8;

   typedef logic [KEY_W-1:0]   key_type;
   typedef logic [FRAME_W-1:0] frame_type;
   typedef logic [RANK_W-1:0]  rank_type;

   typedef struct packed {
      logic      hit;
      frame_type frame;
   } translation_type;

   localparam key_type   KEY_ONES   = '1;
   localparam frame_type FRAME_ONES = '1;

   logic      clock        = 1'b0;
   logic      reset        = 1'b1;
   logic      start        = 1'b0;
   logic      req_command  = tlb_pkg::CMD_LOOKUP;
   key_type   req_key      = '0;
   frame_type req_frame_in = '0;
   logic      busy;
   logic      rsp_strobe;
   logic      rsp_hit;
   frame_type rsp_frame_out;

   // Shadow copy of the buffer contents and the LRU ranks.
   logic      shadow_valid [ENTRIES];
   key_type   shadow_key   [ENTRIES];
   frame_type shadow_frame [ENTRIES];
   rank_type  shadow_rank  [ENTRIES];

   translation_type pending_translations[$];
   key_type         key_pool[POOL_SIZE];
   int              mismatch_count = 0;
   int              gap_percent    = 0;

   tlb_lru_lookup_fill_core #(
      .ENTRIES     (ENTRIES),
      .KEY_WIDTH   (KEY_W),
      .FRAME_WIDTH (FRAME_W)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_command   (req_command),
      .req_key       (req_key),
      .req_frame_in  (req_frame_in),
      .rsp_strobe    (rsp_strobe),
      .rsp_hit       (rsp_hit),
      .rsp_frame_out (rsp_frame_out)
   );

   always #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic clear_shadow();
      for (int i = 0; i < ENTRIES; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_key[i]   = '0;
         shadow_frame[i] = '0;
         shadow_rank[i]  = rank_type'(i);
      end
   endtask

   // The touched entry becomes most recent; everything ranked above it slides down.
   task automatic make_most_recent(input int idx);
      rank_type old_rank;
      old_rank = shadow_rank[idx];
      for (int i = 0; i < ENTRIES; i++) begin
         if (shadow_rank[i] > old_rank) begin
            shadow_rank[i] = shadow_rank[i] - 1'b1;
         end
      end
      shadow_rank[idx] = rank_type'(ENTRIES - 1);
   endtask

   task automatic predict_translation(input logic cmd, input key_type key,
                                      input frame_type frame);
      int   at;
      logic found;
      if (cmd == tlb_pkg::CMD_LOOKUP) begin
         found = 1'b0;
         at    = 0;
         // The highest matching index wins, though duplicates should never exist.
         for (int i = 0; i < ENTRIES; i++) begin
            if (shadow_valid[i] && shadow_key[i] == key) begin
               found = 1'b1;
               at    = i;
            end
         end
         if (found) begin
            pending_translations.push_back(
               translation_type'{hit: 1'b1, frame: shadow_frame[at]});
            make_most_recent(at);
         end else begin
            pending_translations.push_back(translation_type'{hit: 1'b0, frame: '0});
         end
      end else begin
         at = -1;
         for (int i = 0; i < ENTRIES; i++) begin
            if (at < 0 && shadow_valid[i] && shadow_key[i] == key) begin
               at = i;
            end
         end
         if (at < 0) begin
            at = 0;
            for (int i = 1; i < ENTRIES; i++) begin
               if (shadow_rank[i] < shadow_rank[at]) begin
                  at = i;
               end
            end
         end
         shadow_valid[at] = 1'b1;
         shadow_key[at]   = key;
         shadow_frame[at] = frame;
         make_most_recent(at);
      end
   endtask

   // Called at a rising edge; returns at the rising edge that takes the item.
   // Start is left high so that a following item can go out back to back.
   task automatic send_item(input logic cmd, input key_type key, input frame_type frame);
      logic taken;
      if (gap_percent > 0 && $urandom_range(99) < gap_percent) begin
         start <= 1'b0;
         repeat ($urandom_range(19, 1)) @(posedge clock);
      end
      req_command  <= cmd;
      req_key      <= key;
      req_frame_in <= frame;
      start        <= 1'b1;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = (busy === 1'b0);
         @(posedge clock);
      end
      predict_translation(cmd, key, frame);
   endtask

   always @(negedge clock) begin
      translation_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (pending_translations.size() == 0) begin
            $error("unexpected result: hit=%0b frame_out=%h", rsp_hit, rsp_frame_out);
            mismatch_count++;
         end else begin
            want = pending_translations.pop_front();
            if (rsp_hit !== want.hit) begin
               $error("hit: expected %0b, actual %0b", want.hit, rsp_hit);
               mismatch_count++;
            end
            if (rsp_frame_out !== want.frame) begin
               $error("frame_out: expected %h, actual %h", want.frame, rsp_frame_out);
               mismatch_count++;
            end
         end
      end
   end

   task automatic test_empty_lookups();
      send_item(tlb_pkg::CMD_LOOKUP, '0, FRAME_ONES);
      send_item(tlb_pkg::CMD_LOOKUP, KEY_ONES, '0);
   endtask

   task automatic test_fill_extremes();
      send_item(tlb_pkg::CMD_FILL, '0, FRAME_ONES);
      send_item(tlb_pkg::CMD_FILL, KEY_ONES, '0);
      send_item(tlb_pkg::CMD_LOOKUP, KEY_ONES, FRAME_ONES);
      send_item(tlb_pkg::CMD_LOOKUP, '0, '0);
   endtask

   task automatic test_refill_same_key();
      send_item(tlb_pkg::CMD_FILL, '0, frame_type'(19'h2AAAA));
      send_item(tlb_pkg::CMD_LOOKUP, '0, '0);
      send_item(tlb_pkg::CMD_FILL, KEY_ONES, frame_type'(19'h55555));
      send_item(tlb_pkg::CMD_LOOKUP, KEY_ONES, '0);
   endtask

   task automatic test_lru_eviction();
      send_item(tlb_pkg::CMD_FILL, key_type'(19'h55555), frame_type'(19'h11111));
      send_item(tlb_pkg::CMD_FILL, key_type'(19'h2AAAA), frame_type'(19'h22222));
      // Touch key zero so that the all-ones key is the least recent one.
      send_item(tlb_pkg::CMD_LOOKUP, '0, '0);
      send_item(tlb_pkg::CMD_FILL, key_type'(19'h12345), frame_type'(19'h6789A));
      send_item(tlb_pkg::CMD_LOOKUP, KEY_ONES, '0);
      send_item(tlb_pkg::CMD_LOOKUP, key_type'(19'h55555), '0);
      send_item(tlb_pkg::CMD_LOOKUP, key_type'(19'h12345), '0);
      send_item(tlb_pkg::CMD_LOOKUP, key_type'(19'h2AAAA), '0);
      send_item(tlb_pkg::CMD_LOOKUP, '0, '0);
   endtask

   // Most keys come from a small working set so lookups hit and fills evict;
   // the rest are arbitrary keys that almost always miss.
   task automatic test_random_traffic(input int count);
      logic    cmd;
      key_type key;
      int      choice;
      for (int i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = key_type'($urandom);
      end
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 0) begin
            choice = $urandom_range(2);
            gap_percent = (choice == 0) ? 0 : (choice == 1) ? 10 : 35;
         end
         if (n >= count - 100) begin
            gap_percent = 0;
         end
         if (n % 97 == 96) begin
            key_pool[$urandom_range(POOL_SIZE - 1)] = key_type'($urandom);
         end
         cmd = ($urandom_range(99) < 40) ? tlb_pkg::CMD_FILL : tlb_pkg::CMD_LOOKUP;
         if ($urandom_range(99) < 85) begin
            key = key_pool[$urandom_range(POOL_SIZE - 1)];
         end else begin
            key = key_type'($urandom);
         end
         send_item(cmd, key, frame_type'($urandom));
      end
   endtask

   initial begin
      int waited;
      clear_shadow();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_empty_lookups();
      test_fill_extremes();
      test_refill_same_key();
      test_lru_eviction();
      test_random_traffic(750);

      start <= 1'b0;
      waited = 0;
      while (pending_translations.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_translations.size() != 0) begin
         $error("%0d lookup results never arrived", pending_translations.size());
         mismatch_count += pending_translations.size();
      end
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> tlb_lru_lookup_fill_core.f
rtl/tlb_pkg.sv
rtl/tlb_ram.sv
rtl/tlb_ctrl.sv
rtl/tlb_dp.sv
rtl/tlb_lru_lookup_fill_core.sv
rtl/tlb_checker.sv
dv/tlb_lru_lookup_fill_core_tb.sv
